// ===== sv/irn_pkg.sv =====
// Shared types, constants and numeral pair tables for the Roman numeral converter.
`default_nettype none

package irn_pkg;

  localparam int unsigned NumW       = 12;
  localparam int unsigned CharW      = 7;
  localparam int unsigned PairIdxW   = 4;
  localparam int unsigned PairCount  = 13;
  localparam int unsigned QueueDepth = 2;

  localparam logic [NumW-1:0] NumeralMax = 12'd3999;

  localparam logic [CharW-1:0] ChrC = 7'h43;
  localparam logic [CharW-1:0] ChrD = 7'h44;
  localparam logic [CharW-1:0] ChrI = 7'h49;
  localparam logic [CharW-1:0] ChrL = 7'h4C;
  localparam logic [CharW-1:0] ChrM = 7'h4D;
  localparam logic [CharW-1:0] ChrV = 7'h56;
  localparam logic [CharW-1:0] ChrX = 7'h58;

  // One queued request: a saturated, nonzero number.
  typedef struct packed {
    logic            valid;
    logic [NumW-1:0] number;
  } irn_req_t;

  function automatic logic [NumW-1:0] pair_value(input logic [PairIdxW-1:0] idx);
    logic [NumW-1:0] v;
    unique case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CharW-1:0] pair_first(input logic [PairIdxW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx) inside
      4'd0:                 c = ChrM;
      4'd1, 4'd3, 4'd4:     c = ChrC;
      4'd2:                 c = ChrD;
      4'd5, 4'd7, 4'd8:     c = ChrX;
      4'd6:                 c = ChrL;
      4'd10:                c = ChrV;
      default:              c = ChrI;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] pair_second(input logic [PairIdxW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd1:    c = ChrM;
      4'd3:    c = ChrD;
      4'd5:    c = ChrC;
      4'd7:    c = ChrL;
      4'd9:    c = ChrX;
      default: c = ChrV;
    endcase
    return c;
  endfunction

  function automatic logic pair_has_second(input logic [PairIdxW-1:0] idx);
    return (idx == 4'd1) || (idx == 4'd3) || (idx == 4'd5) ||
           (idx == 4'd7) || (idx == 4'd9) || (idx == 4'd11);
  endfunction

  // Greedy choice: the largest pair value that still fits in the remainder.
  function automatic logic [PairIdxW-1:0] pair_select(input logic [NumW-1:0] rem);
    logic [PairIdxW-1:0] sel;
    sel = PairIdxW'(PairCount - 1);
    for (int i = PairCount - 1; i >= 0; i--) begin
      if (rem >= pair_value(PairIdxW'(i))) begin
        sel = PairIdxW'(i);
      end
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

// ===== sv/irn_front.sv =====
// Input side: saturates the number and drops zeros before queueing the request.
`default_nettype none

module irn_front import irn_pkg::*; (
  input  wire logic            in_valid_i,
  input  wire logic [NumW-1:0] number_i,
  input  wire logic            queue_full_i,
  output logic                 in_stall_o,
  output irn_req_t             push_o
);

  logic accept;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // A zero number has an empty numeral, so it never reaches the queue.
  assign push_o.valid  = accept && (number_i != '0);
  assign push_o.number = (number_i > NumeralMax) ? NumeralMax : number_i;

endmodule

`default_nettype wire

// ===== sv/irn_queue.sv =====
// Short request queue between the front and the letter generator.
`default_nettype none

module irn_queue import irn_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire irn_req_t push_i,
  input  wire logic     pop_i,
  output logic          full_o,
  output irn_req_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [NumW-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o        = (count_q == CntW'(Depth));
  assign head_o.valid  = (count_q != '0);
  assign head_o.number = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.number;
    end
  end

endmodule

`default_nettype wire

// ===== sv/irn_back.sv =====
// Letter generator: walks the greedy pair table and emits one letter per cycle while the output is not stalled.
`default_nettype none

module irn_back import irn_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire irn_req_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output logic [CharW-1:0] char_code_o,
  output logic          last_o
);

  logic [NumW-1:0]     rem_q, rem_d;
  logic [PairIdxW-1:0] pos_q, pos_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    char_q, char_d;
  logic                last_q, last_d;
  logic [PairIdxW-1:0] sel;
  logic                busy, adv;

  assign busy = (rem_q != '0) || pend_q;
  assign adv  = !out_valid_q || !out_stall_i;
  assign sel  = pair_select(rem_q);

  always_comb begin
    rem_d       = rem_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    char_d      = char_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    out_valid_d = adv ? busy : out_valid_q;
    if (!busy) begin
      pop_o = head_i.valid;
      if (head_i.valid) begin
        rem_d = head_i.number;
      end
    end else if (adv) begin
      if (pend_q) begin
        // Second letter of a subtractive pair; its value is already taken off.
        char_d = pair_second(pos_q);
        last_d = (rem_q == '0);
        pend_d = 1'b0;
      end else begin
        char_d = pair_first(sel);
        rem_d  = rem_q - pair_value(sel);
        pend_d = pair_has_second(sel);
        pos_d  = sel;
        last_d = (rem_d == '0) && !pend_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== sv/integer_to_roman_numeral_top.sv =====
// A nonzero number is stored in the queue, then loaded into the generator, then its first letter is registered.
// The generator emits one letter per cycle while the output is not stalled, and loads each number from the queue
// before its first letter; the longest numeral, for 3888, has 15 letters.
// Zero requests are taken but never queued, and produce no letters. Numbers above 3999 read as 3999.
// Reset empties the request queue, clears the generator state and drops the output valid.
`default_nettype none

module integer_to_roman_numeral_top import irn_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [NumW-1:0] number_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [CharW-1:0]     char_code_o,
  output logic                 last_o
);

  irn_req_t push, head;
  logic     queue_full, pop;

  irn_front u_front (
    .in_valid_i   (in_valid_i),
    .number_i     (number_i),
    .queue_full_i (queue_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push)
  );

  irn_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (queue_full),
    .head_o (head)
  );

  irn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !queue_full)
    else $error("request pushed into a full queue");

  // Every emitted letter is one of the seven numeral letters.
  a_letter_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == ChrC || char_code_o == ChrD || char_code_o == ChrI ||
                     char_code_o == ChrL || char_code_o == ChrM || char_code_o == ChrV ||
                     char_code_o == ChrX))
    else $error("output letter outside the numeral alphabet");

  // Inside one numeral the letters follow without a gap.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a numeral");

  // Queue head is only popped while a nonzero, in-range request is present.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid && (head.number != '0) && (head.number <= NumeralMax))
    else $error("popped an empty or out-of-range request");

endmodule

`default_nettype wire
